// File: src/wbdmr_pkg.sv
// ----------------------------------------------------------------------------
// wbdmr_pkg: shared types and constants for the warp/blur/decimate row builder
// Field widths, fixed-point settings, register indexes and tdata layout.
// ----------------------------------------------------------------------------
package wbdmr_pkg;

	// fixed settings of the operator
	localparam int MAX_BLUR       = 7;
	localparam int MAX_LOW_DIM    = 2048;
	localparam int COEF_FRAC_BITS = 10;

	// field widths
	localparam int PIX_W      = 11;
	localparam int OFS_W      = 16;
	localparam int COL_W      = 28;
	localparam int TAP_W      = 6;
	localparam int CNT_W      = 28;
	localparam int MODE_W     = 2;
	localparam int COEF_W     = 21;
	localparam int COEF_ROW_W = 63;
	localparam int SCL_W      = 4;
	localparam int BLUR_W     = 3;
	localparam int DIMREG_W   = 12;

	// datapath widths
	localparam int TX_W      = 21;  // (pix << 8) + offset
	localparam int LIN_W     = 34;  // one matrix row times (x, y, 1)
	localparam int NUM_W     = 38;  // row value times scale
	localparam int DEN_W     = 34;  // divisor magnitude
	localparam int COORD_W   = 40;  // warped high-res coordinate
	localparam int DIM_W     = 16;  // high-res width and height
	localparam int MUL_A_W   = 36;
	localparam int MUL_B_W   = 22;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
	localparam int DIV_CNT_W = $clog2(NUM_W);

	// stream and configuration port widths
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	// motion modes, perspective is any code with the upper bit set
	localparam logic [MODE_W-1:0] MODE_GENERAL = 2'd0;
	localparam logic [MODE_W-1:0] MODE_AFFINE  = 2'd1;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MOTION_MODE = 3'd0,
		REG_COEF_ROW0   = 3'd1,
		REG_COEF_ROW1   = 3'd2,
		REG_COEF_ROW2   = 3'd3,
		REG_SCALE       = 3'd4,
		REG_BLUR_SIZE   = 3'd5,
		REG_LOW_WIDTH   = 3'd6,
		REG_LOW_HEIGHT  = 3'd7
	} cfg_reg_t;

	// one matrix entry on its way out
	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [TAP_W-1:0] tap;
	} entry_t;

endpackage

// File: src/warp_blur_decimate_matrix_rows.sv
// ----------------------------------------------------------------------------
// warp_blur_decimate_matrix_rows: sparse matrix row builder
// Each input transaction names one low-res pixel. The block warps it with
// per-pixel offsets, an affine or a perspective matrix, then walks the
// blur_size x blur_size kernel and emits one output transaction per tap that
// falls inside the high-res image (column index and tap number), the last one
// flagged with tlast and carrying the running nonzero count. A row with no
// kept tap gives a single transaction with tuser low. All multiplications go
// through one registered 36x22 multiplier and the perspective divisions through
// one restoring divider that retires a quotient bit per cycle. A new pixel is
// taken only once the previous one has closed its row. The tap walk gives
// one entry per cycle and only waits when an entry is held while the output
// register is still stalled. The walk keeps one entry in reserve so that
// tlast lands on the true final entry.
// ----------------------------------------------------------------------------
module warp_blur_decimate_matrix_rows (
	input  logic                                clk,
	input  logic                                arst_n,
	// input stream
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// pix_x, pix_y, motion_dx, motion_dy (from bit 0 up), two pad bits
	input  logic [wbdmr_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// frame_start
	input  logic [0:0]                          s_axis_tuser,
	// output stream
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// col_index, tap_index, row_end_count (from bit 0 up), two pad bits
	output logic [wbdmr_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	// entry_valid
	output logic [0:0]                          m_axis_tuser,
	output logic                                m_axis_tlast,
	// configuration writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [wbdmr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wbdmr_pkg::CFG_DATA_W-1:0]    cfg_data
);

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DIMW,
		ST_DIMH,
		ST_GEN0,
		ST_GEN1,
		ST_GEN2,
		ST_MAT0,
		ST_MAT1,
		ST_MAT2,
		ST_MAT3,
		ST_MAT4,
		ST_MAT5,
		ST_MAT6,
		ST_MAT7,
		ST_MAT8,
		ST_DIVX,
		ST_FIXX,
		ST_DIVY,
		ST_FIXY,
		ST_ORG,
		ST_BASE,
		ST_LOAD,
		ST_TAPS,
		ST_FIN
	} state_t;

	// configuration registers
	logic [wbdmr_pkg::MODE_W-1:0]     motion_mode_q;
	logic [wbdmr_pkg::COEF_ROW_W-1:0] coef_row0_q;
	logic [wbdmr_pkg::COEF_ROW_W-1:0] coef_row1_q;
	logic [wbdmr_pkg::COEF_ROW_W-1:0] coef_row2_q;
	logic [wbdmr_pkg::SCL_W-1:0]      scale_q;
	logic [wbdmr_pkg::BLUR_W-1:0]     blur_size_q;
	logic [wbdmr_pkg::DIMREG_W-1:0]   low_width_q;
	logic [wbdmr_pkg::DIMREG_W-1:0]   low_height_q;

	// control
	state_t                           state_q;
	logic [wbdmr_pkg::CNT_W-1:0]      running_count_q;
	logic [wbdmr_pkg::BLUR_W-1:0]     i_q;
	logic [wbdmr_pkg::BLUR_W-1:0]     j_q;
	logic [wbdmr_pkg::TAP_W-1:0]      tap_q;
	logic [wbdmr_pkg::DIV_CNT_W-1:0]  div_cnt_q;
	logic                             pend_q;
	wbdmr_pkg::entry_t                pend_entry_q;

	// output register
	logic                             out_valid_q;
	wbdmr_pkg::entry_t                out_entry_q;
	logic                             out_flag_q;
	logic [wbdmr_pkg::CNT_W-1:0]      out_cnt_q;
	logic                             out_last_q;

	// latched input transaction
	logic [wbdmr_pkg::PIX_W-1:0]      px_q;
	logic [wbdmr_pkg::PIX_W-1:0]      py_q;
	logic signed [wbdmr_pkg::OFS_W-1:0] dx_q;
	logic signed [wbdmr_pkg::OFS_W-1:0] dy_q;

	// datapath registers
	logic signed [wbdmr_pkg::MUL_P_W-1:0] prod_s1;
	logic [wbdmr_pkg::DIM_W-1:0]          hw_q;
	logic [wbdmr_pkg::DIM_W-1:0]          hh_q;
	logic signed [wbdmr_pkg::LIN_W-1:0]   acc_q;
	logic signed [wbdmr_pkg::LIN_W-1:0]   u_q;
	logic signed [wbdmr_pkg::LIN_W-1:0]   v_q;
	logic signed [wbdmr_pkg::LIN_W-1:0]   d_q;
	logic signed [wbdmr_pkg::NUM_W-1:0]   nu_q;
	logic signed [wbdmr_pkg::NUM_W-1:0]   nv_q;
	logic signed [wbdmr_pkg::COORD_W-1:0] x0_q;
	logic signed [wbdmr_pkg::COORD_W-1:0] y0_q;
	logic signed [wbdmr_pkg::COORD_W-1:0] xs_q;
	logic signed [wbdmr_pkg::COORD_W-1:0] ys_q;
	logic signed [wbdmr_pkg::COORD_W-1:0] x_q;
	logic signed [wbdmr_pkg::COORD_W-1:0] y_q;
	logic [wbdmr_pkg::COL_W-1:0]          rowbase_q;

	// divider registers
	logic [wbdmr_pkg::NUM_W-1:0]          nq_q;
	logic [wbdmr_pkg::DEN_W-1:0]          dv_q;
	logic [wbdmr_pkg::DEN_W-1:0]          rem_q;
	logic                                 neg_q;

	// combinational
	logic [wbdmr_pkg::DIMREG_W-1:0]       lw_sat;
	logic [wbdmr_pkg::DIMREG_W-1:0]       lh_sat;
	logic [wbdmr_pkg::BLUR_W-1:0]         bs_sat;
	logic [wbdmr_pkg::BLUR_W-1:0]         bs_last;
	logic [wbdmr_pkg::BLUR_W-1:0]         half;
	logic signed [wbdmr_pkg::COEF_W-1:0]  c00, c01, c02, c10, c11, c12, c20, c21, c22;
	logic signed [wbdmr_pkg::TX_W-1:0]    tx;
	logic signed [wbdmr_pkg::TX_W-1:0]    ty;
	logic signed [wbdmr_pkg::MUL_A_W-1:0] mul_a;
	logic signed [wbdmr_pkg::MUL_B_W-1:0] mul_b;
	logic [wbdmr_pkg::NUM_W-1:0]          num_abs_u;
	logic [wbdmr_pkg::NUM_W-1:0]          num_abs_v;
	logic [wbdmr_pkg::DEN_W-1:0]          den_abs;
	logic [wbdmr_pkg::DEN_W:0]            rem_sh;
	logic                                 rem_ge;
	logic [wbdmr_pkg::DEN_W-1:0]          rem_nx;
	logic signed [wbdmr_pkg::COORD_W-1:0] quot_fix;
	logic                                 x_ok;
	logic                                 y_ok;
	logic                                 tap_kept;
	logic [wbdmr_pkg::COL_W-1:0]          tap_col;
	logic                                 out_free;
	logic                                 tap_step;
	logic                                 row_done;
	logic                                 in_accept;

	// settings after saturation
	assign lw_sat  = (low_width_q > wbdmr_pkg::DIMREG_W'(wbdmr_pkg::MAX_LOW_DIM)) ?
		wbdmr_pkg::DIMREG_W'(wbdmr_pkg::MAX_LOW_DIM) : low_width_q;
	assign lh_sat  = (low_height_q > wbdmr_pkg::DIMREG_W'(wbdmr_pkg::MAX_LOW_DIM)) ?
		wbdmr_pkg::DIMREG_W'(wbdmr_pkg::MAX_LOW_DIM) : low_height_q;
	assign bs_sat  = (blur_size_q > wbdmr_pkg::BLUR_W'(wbdmr_pkg::MAX_BLUR)) ?
		wbdmr_pkg::BLUR_W'(wbdmr_pkg::MAX_BLUR) : blur_size_q;
	assign bs_last = bs_sat - wbdmr_pkg::BLUR_W'(1);
	assign half    = bs_sat >> 1;

	// matrix coefficients, three per row
	assign c00 = coef_row0_q[wbdmr_pkg::COEF_W-1:0];
	assign c01 = coef_row0_q[2*wbdmr_pkg::COEF_W-1:wbdmr_pkg::COEF_W];
	assign c02 = coef_row0_q[3*wbdmr_pkg::COEF_W-1:2*wbdmr_pkg::COEF_W];
	assign c10 = coef_row1_q[wbdmr_pkg::COEF_W-1:0];
	assign c11 = coef_row1_q[2*wbdmr_pkg::COEF_W-1:wbdmr_pkg::COEF_W];
	assign c12 = coef_row1_q[3*wbdmr_pkg::COEF_W-1:2*wbdmr_pkg::COEF_W];
	assign c20 = coef_row2_q[wbdmr_pkg::COEF_W-1:0];
	assign c21 = coef_row2_q[2*wbdmr_pkg::COEF_W-1:wbdmr_pkg::COEF_W];
	assign c22 = coef_row2_q[3*wbdmr_pkg::COEF_W-1:2*wbdmr_pkg::COEF_W];

	// offset positions in signed Q12.8 for general motion
	assign tx = $signed({2'b00, px_q, 8'h00}) + wbdmr_pkg::TX_W'(dx_q);
	assign ty = $signed({2'b00, py_q, 8'h00}) + wbdmr_pkg::TX_W'(dy_q);

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_DIMW: begin
				mul_a = wbdmr_pkg::MUL_A_W'($signed({1'b0, lw_sat}));
				mul_b = wbdmr_pkg::MUL_B_W'($signed({1'b0, scale_q}));
			end
			ST_DIMH: begin
				mul_a = wbdmr_pkg::MUL_A_W'($signed({1'b0, lh_sat}));
				mul_b = wbdmr_pkg::MUL_B_W'($signed({1'b0, scale_q}));
			end
			ST_GEN0: begin
				mul_a = wbdmr_pkg::MUL_A_W'(tx);
				mul_b = wbdmr_pkg::MUL_B_W'($signed({1'b0, scale_q}));
			end
			ST_GEN1: begin
				mul_a = wbdmr_pkg::MUL_A_W'(ty);
				mul_b = wbdmr_pkg::MUL_B_W'($signed({1'b0, scale_q}));
			end
			ST_MAT0: begin
				mul_a = wbdmr_pkg::MUL_A_W'($signed({1'b0, px_q}));
				mul_b = wbdmr_pkg::MUL_B_W'(c00);
			end
			ST_MAT1: begin
				mul_a = wbdmr_pkg::MUL_A_W'($signed({1'b0, py_q}));
				mul_b = wbdmr_pkg::MUL_B_W'(c01);
			end
			ST_MAT2: begin
				mul_a = wbdmr_pkg::MUL_A_W'($signed({1'b0, px_q}));
				mul_b = wbdmr_pkg::MUL_B_W'(c10);
			end
			ST_MAT3: begin
				mul_a = wbdmr_pkg::MUL_A_W'($signed({1'b0, py_q}));
				mul_b = wbdmr_pkg::MUL_B_W'(c11);
			end
			ST_MAT4: begin
				mul_a = wbdmr_pkg::MUL_A_W'($signed({1'b0, px_q}));
				mul_b = wbdmr_pkg::MUL_B_W'(c20);
			end
			ST_MAT5: begin
				mul_a = wbdmr_pkg::MUL_A_W'($signed({1'b0, py_q}));
				mul_b = wbdmr_pkg::MUL_B_W'(c21);
			end
			ST_MAT6: begin
				mul_a = wbdmr_pkg::MUL_A_W'(u_q);
				mul_b = wbdmr_pkg::MUL_B_W'($signed({1'b0, scale_q}));
			end
			ST_MAT7: begin
				mul_a = wbdmr_pkg::MUL_A_W'(v_q);
				mul_b = wbdmr_pkg::MUL_B_W'($signed({1'b0, scale_q}));
			end
			ST_BASE: begin
				mul_a = wbdmr_pkg::MUL_A_W'($signed({1'b0, ys_q[wbdmr_pkg::COL_W-1:0]}));
				mul_b = wbdmr_pkg::MUL_B_W'($signed({1'b0, hw_q}));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// divider operands and one restoring step
	assign num_abs_u = nu_q[wbdmr_pkg::NUM_W-1] ? $unsigned(-nu_q) : $unsigned(nu_q);
	assign num_abs_v = nv_q[wbdmr_pkg::NUM_W-1] ? $unsigned(-nv_q) : $unsigned(nv_q);
	assign den_abs   = d_q[wbdmr_pkg::LIN_W-1] ? $unsigned(-d_q) : $unsigned(d_q);
	assign rem_sh    = {rem_q, nq_q[wbdmr_pkg::NUM_W-1]};
	assign rem_ge    = rem_sh >= {1'b0, dv_q};
	assign rem_nx    = rem_ge ? wbdmr_pkg::DEN_W'(rem_sh - {1'b0, dv_q}) :
		wbdmr_pkg::DEN_W'(rem_sh);

	// floor correction when the signs differ
	always_comb begin
		if (neg_q) begin
			quot_fix = -($signed(wbdmr_pkg::COORD_W'(nq_q)) +
				$signed(wbdmr_pkg::COORD_W'(rem_q != '0)));
		end else begin
			quot_fix = $signed(wbdmr_pkg::COORD_W'(nq_q));
		end
	end

	// current tap: bounds test and linear column
	assign x_ok     = !x_q[wbdmr_pkg::COORD_W-1] &&
		(x_q[wbdmr_pkg::COORD_W-2:0] < (wbdmr_pkg::COORD_W-1)'(hw_q));
	assign y_ok     = !y_q[wbdmr_pkg::COORD_W-1] &&
		(y_q[wbdmr_pkg::COORD_W-2:0] < (wbdmr_pkg::COORD_W-1)'(hh_q));
	assign tap_kept = x_ok && y_ok;
	assign tap_col  = rowbase_q + x_q[wbdmr_pkg::COL_W-1:0];
	assign out_free = !out_valid_q || m_axis_tready;
	assign tap_step = (state_q == ST_TAPS) && !(tap_kept && pend_q && !out_free);
	assign row_done = (j_q == bs_last);

	// handshakes
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	// output port
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_cnt_q, out_entry_q.tap, out_entry_q.col};
	assign m_axis_tuser  = out_flag_q;
	assign m_axis_tlast  = out_last_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motion_mode_q <= wbdmr_pkg::MODE_AFFINE;
			coef_row0_q   <= wbdmr_pkg::COEF_ROW_W'(64'd1024);
			coef_row1_q   <= wbdmr_pkg::COEF_ROW_W'(64'd1024) << wbdmr_pkg::COEF_W;
			coef_row2_q   <= wbdmr_pkg::COEF_ROW_W'(64'd1024) << (2*wbdmr_pkg::COEF_W);
			scale_q       <= wbdmr_pkg::SCL_W'(4);
			blur_size_q   <= wbdmr_pkg::BLUR_W'(5);
			low_width_q   <= wbdmr_pkg::DIMREG_W'(640);
			low_height_q  <= wbdmr_pkg::DIMREG_W'(480);
		end else if (cfg_valid && cfg_ready) begin
			unique case (wbdmr_pkg::cfg_reg_t'(cfg_index))
				wbdmr_pkg::REG_MOTION_MODE: motion_mode_q <= cfg_data[wbdmr_pkg::MODE_W-1:0];
				wbdmr_pkg::REG_COEF_ROW0:   coef_row0_q <= cfg_data[wbdmr_pkg::COEF_ROW_W-1:0];
				wbdmr_pkg::REG_COEF_ROW1:   coef_row1_q <= cfg_data[wbdmr_pkg::COEF_ROW_W-1:0];
				wbdmr_pkg::REG_COEF_ROW2:   coef_row2_q <= cfg_data[wbdmr_pkg::COEF_ROW_W-1:0];
				wbdmr_pkg::REG_SCALE:       scale_q <= cfg_data[wbdmr_pkg::SCL_W-1:0];
				wbdmr_pkg::REG_BLUR_SIZE:   blur_size_q <= cfg_data[wbdmr_pkg::BLUR_W-1:0];
				wbdmr_pkg::REG_LOW_WIDTH:   low_width_q <= cfg_data[wbdmr_pkg::DIMREG_W-1:0];
				wbdmr_pkg::REG_LOW_HEIGHT:  low_height_q <= cfg_data[wbdmr_pkg::DIMREG_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer, running count and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			running_count_q <= '0;
			i_q             <= '0;
			j_q             <= '0;
			tap_q           <= '0;
			div_cnt_q       <= '0;
			pend_q          <= 1'b0;
			pend_entry_q    <= '0;
			out_valid_q     <= 1'b0;
			out_entry_q     <= '0;
			out_flag_q      <= 1'b0;
			out_cnt_q       <= '0;
			out_last_q      <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						if (s_axis_tuser[0]) begin
							running_count_q <= '0;
						end
						state_q <= ST_DIMW;
					end
				end
				ST_DIMW: state_q <= ST_DIMH;
				ST_DIMH: begin
					state_q <= (motion_mode_q == wbdmr_pkg::MODE_GENERAL) ? ST_GEN0 : ST_MAT0;
				end
				ST_GEN0: state_q <= ST_GEN1;
				ST_GEN1: state_q <= ST_GEN2;
				ST_GEN2: state_q <= ST_ORG;
				ST_MAT0: state_q <= ST_MAT1;
				ST_MAT1: state_q <= ST_MAT2;
				ST_MAT2: state_q <= ST_MAT3;
				ST_MAT3: state_q <= ST_MAT4;
				ST_MAT4: state_q <= ST_MAT5;
				ST_MAT5: state_q <= ST_MAT6;
				ST_MAT6: state_q <= ST_MAT7;
				ST_MAT7: state_q <= ST_MAT8;
				ST_MAT8: begin
					div_cnt_q <= wbdmr_pkg::DIV_CNT_W'(wbdmr_pkg::NUM_W - 1);
					if (motion_mode_q == wbdmr_pkg::MODE_AFFINE) begin
						state_q <= ST_ORG;
					end else if (d_q == '0) begin
						// zero denominator: empty row
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_DIVX;
					end
				end
				ST_DIVX: begin
					div_cnt_q <= div_cnt_q - wbdmr_pkg::DIV_CNT_W'(1);
					if (div_cnt_q == '0) begin
						state_q <= ST_FIXX;
					end
				end
				ST_FIXX: begin
					div_cnt_q <= wbdmr_pkg::DIV_CNT_W'(wbdmr_pkg::NUM_W - 1);
					state_q   <= ST_DIVY;
				end
				ST_DIVY: begin
					div_cnt_q <= div_cnt_q - wbdmr_pkg::DIV_CNT_W'(1);
					if (div_cnt_q == '0) begin
						state_q <= ST_FIXY;
					end
				end
				ST_FIXY: state_q <= ST_ORG;
				ST_ORG: begin
					state_q <= (bs_sat == '0) ? ST_FIN : ST_BASE;
				end
				ST_BASE: state_q <= ST_LOAD;
				ST_LOAD: begin
					i_q     <= '0;
					j_q     <= '0;
					tap_q   <= '0;
					state_q <= ST_TAPS;
				end
				ST_TAPS: begin
					if (tap_step) begin
						if (tap_kept) begin
							// an earlier entry is known not to be the last one
							if (pend_q) begin
								out_valid_q <= 1'b1;
								out_entry_q <= pend_entry_q;
								out_flag_q  <= 1'b1;
								out_cnt_q   <= '0;
								out_last_q  <= 1'b0;
							end
							pend_q           <= 1'b1;
							pend_entry_q.col <= tap_col;
							pend_entry_q.tap <= tap_q;
							running_count_q  <= running_count_q + wbdmr_pkg::CNT_W'(1);
						end
						tap_q <= tap_q + wbdmr_pkg::TAP_W'(1);
						if (row_done) begin
							j_q <= '0;
							i_q <= i_q + wbdmr_pkg::BLUR_W'(1);
							if (i_q == bs_last) begin
								state_q <= ST_FIN;
							end
						end else begin
							j_q <= j_q + wbdmr_pkg::BLUR_W'(1);
						end
					end
				end
				ST_FIN: begin
					// closing transaction: held entry, or the empty marker
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_entry_q <= pend_q ? pend_entry_q : '0;
						out_flag_q  <= pend_q;
						out_cnt_q   <= running_count_q;
						out_last_q  <= 1'b1;
						pend_q      <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// arithmetic datapath
	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;

		if (in_accept) begin
			px_q <= s_axis_tdata[wbdmr_pkg::PIX_W-1:0];
			py_q <= s_axis_tdata[2*wbdmr_pkg::PIX_W-1:wbdmr_pkg::PIX_W];
			dx_q <= s_axis_tdata[2*wbdmr_pkg::PIX_W+wbdmr_pkg::OFS_W-1:2*wbdmr_pkg::PIX_W];
			dy_q <= s_axis_tdata[2*wbdmr_pkg::PIX_W+2*wbdmr_pkg::OFS_W-1:
				2*wbdmr_pkg::PIX_W+wbdmr_pkg::OFS_W];
		end

		case (state_q)
			ST_DIMH: hw_q <= wbdmr_pkg::DIM_W'(prod_s1);
			ST_GEN0: hh_q <= wbdmr_pkg::DIM_W'(prod_s1);
			ST_GEN1: x0_q <= wbdmr_pkg::COORD_W'(prod_s1 >>> 8);
			ST_GEN2: y0_q <= wbdmr_pkg::COORD_W'(prod_s1 >>> 8);
			ST_MAT0: hh_q <= wbdmr_pkg::DIM_W'(prod_s1);
			ST_MAT1: acc_q <= wbdmr_pkg::LIN_W'(prod_s1);
			ST_MAT2: u_q <= wbdmr_pkg::LIN_W'(acc_q + prod_s1 + c02);
			ST_MAT3: acc_q <= wbdmr_pkg::LIN_W'(prod_s1);
			ST_MAT4: v_q <= wbdmr_pkg::LIN_W'(acc_q + prod_s1 + c12);
			ST_MAT5: acc_q <= wbdmr_pkg::LIN_W'(prod_s1);
			ST_MAT6: d_q <= wbdmr_pkg::LIN_W'(acc_q + prod_s1 + c22);
			ST_MAT7: nu_q <= wbdmr_pkg::NUM_W'(prod_s1);
			ST_MAT8: begin
				nv_q <= wbdmr_pkg::NUM_W'(prod_s1);
				// affine result by shift, perspective x division set up
				x0_q  <= wbdmr_pkg::COORD_W'(nu_q >>> wbdmr_pkg::COEF_FRAC_BITS);
				y0_q  <= wbdmr_pkg::COORD_W'(prod_s1 >>> wbdmr_pkg::COEF_FRAC_BITS);
				nq_q  <= num_abs_u;
				dv_q  <= den_abs;
				rem_q <= '0;
				neg_q <= nu_q[wbdmr_pkg::NUM_W-1] ^ d_q[wbdmr_pkg::LIN_W-1];
			end
			ST_DIVX, ST_DIVY: begin
				rem_q <= rem_nx;
				nq_q  <= {nq_q[wbdmr_pkg::NUM_W-2:0], rem_ge};
			end
			ST_FIXX: begin
				x0_q  <= quot_fix;
				nq_q  <= num_abs_v;
				rem_q <= '0;
				neg_q <= nv_q[wbdmr_pkg::NUM_W-1] ^ d_q[wbdmr_pkg::LIN_W-1];
			end
			ST_FIXY: y0_q <= quot_fix;
			ST_ORG: begin
				xs_q <= x0_q - wbdmr_pkg::COORD_W'(half);
				ys_q <= y0_q - wbdmr_pkg::COORD_W'(half);
			end
			ST_LOAD: begin
				rowbase_q <= wbdmr_pkg::COL_W'(prod_s1);
				x_q       <= xs_q;
				y_q       <= ys_q;
			end
			ST_TAPS: begin
				if (tap_step) begin
					if (row_done) begin
						x_q       <= xs_q;
						y_q       <= y_q + wbdmr_pkg::COORD_W'(1);
						rowbase_q <= rowbase_q + wbdmr_pkg::COL_W'(hw_q);
					end else begin
						x_q <= x_q + wbdmr_pkg::COORD_W'(1);
					end
				end
			end
			default: ;
		endcase
	end

endmodule

// File: src/wbdmr_checker.sv
// ----------------------------------------------------------------------------
// wbdmr_checker: port-level checks for the row builder
// Watches the stream ports and flags ordering and marking slips.
// ----------------------------------------------------------------------------
module wbdmr_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_axis_tvalid,
	input logic                              s_axis_tready,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [wbdmr_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input logic [0:0]                        m_axis_tuser,
	input logic                              m_axis_tlast
);

	localparam int TAP_LO = wbdmr_pkg::COL_W;
	localparam int CNT_LO = wbdmr_pkg::COL_W + wbdmr_pkg::TAP_W;

	// block is busy right after taking a pixel
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while previous pixel still in work");

	// a stalled output transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled output transaction changed");

	// the empty marker is always the closing transaction and carries no entry
	a_empty_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |->
			m_axis_tlast && (m_axis_tdata[CNT_LO-1:0] == '0))
		else $error("empty marker not last or not cleared");

	// row pointer only on the closing transaction
	a_count_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |->
			m_axis_tdata[CNT_LO+wbdmr_pkg::CNT_W-1:CNT_LO] == '0)
		else $error("row count on a non-final transaction");

	// tap number stays inside the largest kernel
	a_tap_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			m_axis_tdata[CNT_LO-1:TAP_LO] <
				wbdmr_pkg::TAP_W'(wbdmr_pkg::MAX_BLUR * wbdmr_pkg::MAX_BLUR))
		else $error("tap number out of kernel range");

endmodule

bind warp_blur_decimate_matrix_rows wbdmr_checker u_wbdmr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
